// File: design/wfr_pkg.sv
`default_nettype none
package wfr_pkg;

  // Framing
  localparam int unsigned MAX_DATA    = 1024;
  localparam int unsigned HDR_BYTES   = 9;   // start byte, 4 sequence, 4 length
  localparam int unsigned SEQ_LAST    = 4;   // last sequence byte position
  localparam int unsigned REPLY_BYTES = 6;

  // Reply codes and the good-sum value
  localparam logic [7:0] CODE_ACK = 8'h06;
  localparam logic [7:0] CODE_NAK = 8'h15;
  localparam logic [7:0] GOOD_SUM = 8'hFF;

  // Window register
  localparam int unsigned WIN_W     = 11;
  localparam logic [WIN_W-1:0] WIN_RESET = 11'd8;

  // Reply byte counter
  localparam int unsigned CNT_W = $clog2(REPLY_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REPLY_BYTES - 1);

  // One reply, as handed from the parser to the sender
  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] seq;
    logic [7:0]  sum;
  } reply_t;

endpackage
`default_nettype wire

// File: design/window_frame_receiver_top.sv
`default_nettype none
// Channel  | Ports                          | Moves
// ---------+--------------------------------+------------------------------
// in       | in_valid, in_ready, in_byte    | one received frame byte
// out      | out_valid, out_ready, out_byte,| one reply byte, out_last on
//          | out_last                       | the sixth
// cfg      | cfg_valid, cfg_ready, cfg_data | window_size write
//
// One frame byte is taken per cycle while in_ready is high; the frame tracker decides the reply on
// the checksum byte and loads the reply register in the same cycle.
// A reply leaves as six bytes from that register, paced by out_ready.
// The checksum byte of the next frame waits while a reply is still pending,
// so in_ready drops only when the out side stalls.
// Synchronous active-low reset; cfg_ready is always high.
module window_frame_receiver_top #(
  parameter int unsigned MaxData = wfr_pkg::MAX_DATA
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_last,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [wfr_pkg::WIN_W-1:0] cfg_data
);
  import wfr_pkg::*;

  logic [WIN_W-1:0] window_r, window_nxt;
  logic             in_acc;
  logic             at_cksum;
  logic             rep_vld;
  reply_t           rep;
  logic             tx_busy;

  // Window register
  assign cfg_ready  = 1'b1;
  assign window_nxt = (cfg_valid && cfg_ready) ? cfg_data : window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  // Hold the checksum byte while a reply is pending
  assign in_ready = !(at_cksum && tx_busy);
  assign in_acc   = in_valid && in_ready;

  wfr_parser #(
    .MaxData (MaxData)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_acc      (in_acc),
    .in_byte     (in_byte),
    .window_size (window_r),
    .at_cksum    (at_cksum),
    .rep_vld     (rep_vld),
    .rep         (rep)
  );

  wfr_reply_tx u_reply_tx (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (rep_vld),
    .rep       (rep),
    .busy      (tx_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire

// File: design/wfr_parser.sv
`default_nettype none
module wfr_parser #(
  parameter int unsigned MaxData = wfr_pkg::MAX_DATA
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_acc,
  input  wire logic [7:0]               in_byte,
  input  wire logic [wfr_pkg::WIN_W-1:0] window_size,
  output logic                          at_cksum,
  output logic                          rep_vld,
  output wfr_pkg::reply_t               rep
);
  import wfr_pkg::*;

  localparam int unsigned LenW  = $clog2(MaxData + 1);
  localparam int unsigned PosW  = $clog2(MaxData + HDR_BYTES + 1);
  localparam int unsigned GrowW = LenW + 8;

  logic [PosW-1:0]  pos_r, pos_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [LenW-1:0]  len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [31:0]      exp_r, exp_nxt;

  logic [7:0]       sum_add;
  logic [GrowW-1:0] grown;
  logic             good;
  logic             in_order;
  logic             below_edge;
  logic [31:0]      win_edge;

  // Frame position decode: checksum byte follows header and data
  assign at_cksum = (pos_r >= PosW'(HDR_BYTES)) &&
                    (pos_r == PosW'(HDR_BYTES) + PosW'(len_r));

  assign sum_add = sum_r + in_byte;
  assign grown   = {len_r, in_byte};

  // Reply decision on the checksum byte
  assign good       = (sum_add == GOOD_SUM) && !ovf_r;
  assign in_order   = (seq_r == exp_r);
  assign win_edge   = exp_r - 32'd1 + 32'(window_size);
  assign below_edge = $signed(seq_r) < $signed(win_edge);

  always_comb begin
    rep_vld  = in_acc && at_cksum && (in_order || !good || below_edge);
    rep.sum  = sum_add;
    if (in_order && good) begin
      rep.code = CODE_ACK;
      rep.seq  = seq_r + 32'd1;
    end else begin
      rep.code = CODE_NAK;
      rep.seq  = exp_r;
    end
  end

  // Next state of the frame tracker
  always_comb begin
    pos_nxt = pos_r;
    seq_nxt = seq_r;
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    sum_nxt = sum_r;
    exp_nxt = exp_r;
    if (in_acc) begin
      if (pos_r == '0) begin
        sum_nxt = in_byte;
        seq_nxt = '0;
        len_nxt = '0;
        ovf_nxt = 1'b0;
        pos_nxt = PosW'(1);
      end else if (at_cksum) begin
        sum_nxt = sum_add;
        pos_nxt = '0;
        if (in_order && good) begin
          exp_nxt = exp_r + 32'd1;
        end
      end else begin
        sum_nxt = sum_add;
        pos_nxt = pos_r + PosW'(1);
        if (pos_r <= PosW'(SEQ_LAST)) begin
          seq_nxt = {seq_r[23:0], in_byte};
        end else if (pos_r < PosW'(HDR_BYTES)) begin
          if (!ovf_r) begin
            if (grown > GrowW'(MaxData)) begin
              ovf_nxt = 1'b1;
              len_nxt = LenW'(MaxData);
            end else begin
              len_nxt = grown[LenW-1:0];
            end
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      seq_r <= '0;
      len_r <= '0;
      ovf_r <= 1'b0;
      sum_r <= '0;
      exp_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      seq_r <= seq_nxt;
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      sum_r <= sum_nxt;
      exp_r <= exp_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/wfr_reply_tx.sv
`default_nettype none
module wfr_reply_tx (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire wfr_pkg::reply_t rep,
  output logic                 busy,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);
  import wfr_pkg::*;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  reply_t           rep_r, rep_nxt;
  logic             out_acc;

  assign busy      = busy_r;
  assign out_valid = busy_r;
  assign out_last  = (cnt_r == CNT_LAST);
  assign out_acc   = out_valid && out_ready;

  // Byte select for the current reply position
  always_comb begin
    case (cnt_r)
      CNT_W'(0): out_byte = rep_r.code;
      CNT_W'(1): out_byte = rep_r.seq[31:24];
      CNT_W'(2): out_byte = rep_r.seq[23:16];
      CNT_W'(3): out_byte = rep_r.seq[15:8];
      CNT_W'(4): out_byte = rep_r.seq[7:0];
      default:   out_byte = rep_r.sum;
    endcase
  end

  // Load a new reply or step through the current one
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rep_nxt  = rep_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rep_nxt  = rep;
    end else if (out_acc) begin
      if (out_last) begin
        busy_nxt = 1'b0;
        cnt_nxt  = '0;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rep_r <= rep_nxt;
  end

  // A new reply never lands on one still being sent
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(load && busy_r))
    else $error("reply loaded while previous reply pending");

  // Final byte taken frees the sender
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last) |=> !out_valid)
    else $error("sender still busy after final byte");

  // Counter stays within the reply
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r <= CNT_LAST))
    else $error("reply byte counter out of range");

endmodule
`default_nettype wire
